### rtl/usdm_pkg.sv
// ----------------------------------------------------------------------------
// UART status and data register model: shared package
// Action codes, FIFO sizing and the reset value of the completion delay.
// ----------------------------------------------------------------------------
`default_nettype none

package usdm_pkg;

  // Depth of the receive FIFO and the widths that follow from it.
  localparam int unsigned RxFifoDepth = 16;
  localparam int unsigned RxPtrW      = (RxFifoDepth > 1) ? $clog2(RxFifoDepth) : 1;
  localparam int unsigned RxCntW      = $clog2(RxFifoDepth + 1);

  localparam int unsigned DelayW          = 16;
  localparam logic [15:0] DelayResetValue = 16'd20;

  typedef enum logic [2:0] {
    ACT_TICK        = 3'd0,
    ACT_STATUS_READ = 3'd1,
    ACT_DATA_READ   = 3'd2,
    ACT_DATA_WRITE  = 3'd3,
    ACT_PUSH        = 3'd4
  } action_e;

endpackage

`default_nettype wire

### rtl/usdm_if.sv
// ----------------------------------------------------------------------------
// UART status and data register model: channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

interface usdm_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] data;

  modport source (output valid, output action, output data, input ready);
  modport sink   (input valid, input action, input data, output ready);
endinterface

interface usdm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       rx_not_empty;
  logic       overrun;
  logic       tx_empty;
  logic       tx_complete;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       tx_frame_start;
  logic       push_dropped;

  modport source (output valid, output read_data, output rx_not_empty, output overrun,
                  output tx_empty, output tx_complete, output tx_valid, output tx_byte,
                  output tx_frame_start, output push_dropped, input ready);
  modport sink   (input valid, input read_data, input rx_not_empty, input overrun,
                  input tx_empty, input tx_complete, input tx_valid, input tx_byte,
                  input tx_frame_start, input push_dropped, output ready);
endinterface

interface usdm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/uart_status_data_model.sv
// ----------------------------------------------------------------------------
// UART status and data register model
// Serial port register model driven by tick, register access and push items.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item passes the input register, then the result register,
//   since one pass of flag logic does all of its work.
// Throughput: one item per cycle without stalls; a stalled result leaves room for one more item.
// Reset: rst_ni is asynchronous and active low; all flags, pointers, counters
//   and the completion delay (20) take their reset values at once, so no
//   clearing pass is needed. FIFO entries are read only after being pushed.
// ----------------------------------------------------------------------------
`default_nettype none

module uart_status_data_model
  import usdm_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  usdm_req_if.sink     in_i,
  usdm_rsp_if.source   out_o,
  usdm_cfg_if.sink     cfg_i
);

  // Architectural state of the register model, apart from the FIFO storage.
  typedef struct packed {
    logic [7:0]        data_reg;
    logic              rxne;
    logic              ore;
    logic              txe;
    logic              tc;
    logic [7:0]        rx_shift;
    logic              rx_shift_full;
    logic              rx_receiving;
    logic [7:0]        tx_shift;
    logic              tx_shift_full;
    logic              tx_sending;
    logic              tx_busy;
    logic              clear_armed;
    logic              tc_pending;
    logic [DelayW-1:0] tc_countdown;
    logic              frame_open;
    logic [RxCntW-1:0] rx_count;
    logic [RxPtrW-1:0] rx_head;
    logic [RxPtrW-1:0] rx_tail;
  } state_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rx_not_empty;
    logic       overrun;
    logic       tx_empty;
    logic       tx_complete;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_frame_start;
    logic       push_dropped;
  } result_t;

  localparam logic [RxPtrW-1:0] HeadLast = RxPtrW'(RxFifoDepth - 1);
  localparam logic [RxCntW-1:0] CntFull  = RxCntW'(RxFifoDepth);

  state_t            state_q, state_d;
  item_t             item_q;
  logic              item_valid_q;
  result_t           res_q, res_d;
  logic              res_valid_q;
  logic [DelayW-1:0] delay_q;
  logic [7:0]        fifo_q [RxFifoDepth];
  logic              fifo_we;
  logic              advance;

  // The item in the input register is processed as soon as the result
  // register is free or is being emptied in the same cycle.
  assign advance     = item_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready  = !item_valid_q || advance;
  assign cfg_i.ready = 1'b1;

  // Configuration is to be written only while the block is idle; the block does not enforce this.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayResetValue;
    end else if (cfg_i.valid) begin
      delay_q <= cfg_i.data;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      item_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q <= '{action: in_i.action, data: in_i.data};
    end
  end

  // One pass through the model's rules. The order of the steps matters:
  // a tick runs receive first, so transmit sees the data register after any
  // shift stage transfer, and a data read clears the receive flag before
  // retrying that transfer and clears overrun only after it.
  always_comb begin
    state_t s;
    result_t r;
    logic    do_move;
    logic    is_tick;

    s       = state_q;
    r       = '0;
    do_move = 1'b0;
    is_tick = 1'b0;
    fifo_we = 1'b0;

    r.rx_not_empty = state_q.rxne;
    r.overrun      = state_q.ore;
    r.tx_empty     = state_q.txe;
    r.tx_complete  = state_q.tc;

    unique case (action_e'(item_q.action))
      ACT_TICK: begin
        is_tick = 1'b1;
        if (s.rx_receiving) begin
          s.rx_receiving = 1'b0;
          if (s.rx_count != '0) begin
            s.rx_shift      = fifo_q[s.rx_head];
            s.rx_shift_full = 1'b1;
          end
        end else if (s.rx_shift_full) begin
          do_move = 1'b1;
        end else if (s.rx_count != '0) begin
          s.rx_receiving = 1'b1;
        end
      end
      ACT_STATUS_READ: begin
        if (s.ore) begin
          s.clear_armed = 1'b1;
        end
      end
      ACT_DATA_READ: begin
        r.read_data = s.data_reg;
        s.rxne      = 1'b0;
        do_move     = 1'b1;
      end
      ACT_DATA_WRITE: begin
        s.data_reg     = item_q.data;
        s.txe          = 1'b0;
        s.tc           = 1'b0;
        s.tx_busy      = 1'b1;
        s.tc_pending   = 1'b0;
        s.tc_countdown = '0;
      end
      ACT_PUSH: begin
        if (s.rx_count == CntFull) begin
          r.push_dropped = 1'b1;
        end else begin
          fifo_we    = 1'b1;
          s.rx_tail  = (s.rx_tail == HeadLast) ? '0 : s.rx_tail + 1'b1;
          s.rx_count = s.rx_count + 1'b1;
        end
      end
      default: begin
      end
    endcase

    // Shift stage to data register; a still-set receive flag means overrun.
    if (do_move && s.rx_shift_full) begin
      if (s.rxne) begin
        s.ore = 1'b1;
      end else begin
        s.data_reg      = s.rx_shift;
        s.rxne          = 1'b1;
        s.rx_shift_full = 1'b0;
        s.rx_receiving  = 1'b1;
        if (s.rx_count != '0) begin
          s.rx_head  = (s.rx_head == HeadLast) ? '0 : s.rx_head + 1'b1;
          s.rx_count = s.rx_count - 1'b1;
        end
      end
    end

    if (action_e'(item_q.action) == ACT_DATA_READ && s.clear_armed) begin
      s.clear_armed = 1'b0;
      s.ore         = 1'b0;
    end

    // Transmit path, only on a tick and only while the transmitter is busy.
    if (is_tick && s.tx_busy) begin
      if (s.tc_pending && s.tc_countdown != '0) begin
        s.tc_countdown = s.tc_countdown - 1'b1;
      end
      if (s.tx_sending) begin
        r.tx_valid       = 1'b1;
        r.tx_byte        = s.tx_shift;
        r.tx_frame_start = !s.frame_open;
        s.frame_open     = 1'b1;
        s.tx_shift_full  = 1'b0;
        s.tx_sending     = 1'b0;
        s.tc_pending     = 1'b1;
        s.tc_countdown   = delay_q;
      end else if (s.tx_shift_full) begin
        s.tx_sending = 1'b1;
      end else if (!s.txe) begin
        s.tx_shift      = s.data_reg;
        s.tx_shift_full = 1'b1;
        s.txe           = 1'b1;
      end else if (s.tc_pending && s.tc_countdown == '0) begin
        s.frame_open = 1'b0;
        s.tx_busy    = 1'b0;
        s.tc_pending = 1'b0;
        s.tc         = 1'b1;
      end
    end

    state_d = s;
    res_d   = r;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{
        data_reg:      8'h00,
        rxne:          1'b0,
        ore:           1'b0,
        txe:           1'b1,
        tc:            1'b1,
        rx_shift:      8'h00,
        rx_shift_full: 1'b0,
        rx_receiving:  1'b0,
        tx_shift:      8'h00,
        tx_shift_full: 1'b0,
        tx_sending:    1'b0,
        tx_busy:       1'b0,
        clear_armed:   1'b0,
        tc_pending:    1'b0,
        tc_countdown:  '0,
        frame_open:    1'b0,
        rx_count:      '0,
        rx_head:       '0,
        rx_tail:       '0
      };
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // FIFO storage is written only at the tail, so it needs no reset.
  always_ff @(posedge clk_i) begin
    if (advance && fifo_we) begin
      fifo_q[state_q.rx_tail] <= item_q.data;
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid          = res_valid_q;
  assign out_o.read_data      = res_q.read_data;
  assign out_o.rx_not_empty   = res_q.rx_not_empty;
  assign out_o.overrun        = res_q.overrun;
  assign out_o.tx_empty       = res_q.tx_empty;
  assign out_o.tx_complete    = res_q.tx_complete;
  assign out_o.tx_valid       = res_q.tx_valid;
  assign out_o.tx_byte        = res_q.tx_byte;
  assign out_o.tx_frame_start = res_q.tx_frame_start;
  assign out_o.push_dropped   = res_q.push_dropped;

endmodule

`default_nettype wire
